[design/i2c_master_bit_sequencer_defines.svh]
// Assertion macros for the I2C master bit sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/i2cms_pkg.sv]
// Types and constants of the I2C master bit sequencer.
package i2cms_pkg;

  localparam int DIV_W = 16;

  // Opcode field values.
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ_ACK  = 3'd3;
  localparam logic [2:0] OP_READ_NACK = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  localparam logic [DIV_W-1:0] TPP_RESET = DIV_W'(250);

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_STOP      = 3'd1,
    CMD_WRITE     = 3'd2,
    CMD_READ_ACK  = 3'd3,
    CMD_READ_NACK = 3'd4,
    CMD_IDLE      = 3'd7
  } cmd_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_data;
    logic       cmd_rejected;
  } res_t;

endpackage

[design/i2cms_cmd_if.sv]
// Input item channel: opcode, byte and sampled SDA level.
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       sda_in;

  modport source (output valid, output opcode, output data_byte, output sda_in, input ready);
  modport sink (input valid, input opcode, input data_byte, input sda_in, output ready);
endinterface

[design/i2cms_res_if.sv]
// Result item channel: pin levels and status.
interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic       ack_seen;
  logic [7:0] read_data;
  logic       cmd_rejected;

  modport source (output valid, output scl_release, output sda_release, output busy_res,
                  output done_res, output ack_seen, output read_data, output cmd_rejected,
                  input ready);
  modport sink (input valid, input scl_release, input sda_release, input busy_res,
                input done_res, input ack_seen, input read_data, input cmd_rejected,
                output ready);
endinterface

[design/i2cms_cfg_if.sv]
// Configuration write channel for the phase length register.
interface i2cms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/i2c_master_bit_sequencer.sv]
// I2C master bit sequencer: one result item per input item, one item per cycle while the output side is ready.
// The result of an item is registered and is on the output channel in the cycle after it is accepted.
// One item per cycle while the output side is ready; the single result register is refilled as it is taken.
// Reset (synchronous, active high): idle, both lines released, phase length 250 ticks.
// A held result only stalls input while the output side is not ready.
`include "i2c_master_bit_sequencer_defines.svh"
module i2c_master_bit_sequencer (
  input logic         clk,
  input logic         rst,
  i2cms_cmd_if.sink   cmd,
  i2cms_res_if.source res,
  i2cms_cfg_if.sink   cfg
);
  import i2cms_pkg::*;

  logic [DIV_W-1:0] ticks_per_phase;
  logic             fire;
  res_t             core_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= TPP_RESET;
    end else if (cfg.valid) begin
      ticks_per_phase <= cfg.data;
    end
  end

  assign fire = cmd.valid && cmd.ready;

  i2cms_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .opcode          (cmd.opcode),
    .data_byte       (cmd.data_byte),
    .sda_in          (cmd.sda_in),
    .ticks_per_phase (ticks_per_phase),
    .res             (core_res)
  );

  i2cms_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .in_res   (core_res),
    .res      (res)
  );

  `I2CMS_ASSERT_NOW(a_done_leaves_idle, core_res.done_res, !core_res.busy_res, "done while busy")
  `I2CMS_ASSERT_NOW(a_reject_needs_busy, core_res.cmd_rejected, core_res.busy_res && !core_res.done_res, "reject while idle")
  `I2CMS_ASSERT_NEXT(a_stall_blocks_input, res.valid && !res.ready, res.valid && (cmd.ready == res.ready), "stall not seen")

endmodule

[design/i2cms_core.sv]
// Bus sequencing state and per-item result logic.
module i2cms_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [2:0]               opcode,
  input  logic [7:0]               data_byte,
  input  logic                     sda_in,
  input  logic [i2cms_pkg::DIV_W-1:0] ticks_per_phase,
  output i2cms_pkg::res_t          res
);
  import i2cms_pkg::*;

  cmd_t             cmd, cmd_next;
  logic [1:0]       step, step_next;
  logic [3:0]       bit_idx, bit_idx_next;
  logic [7:0]       shift, shift_next;
  logic [DIV_W-1:0] div, div_next;
  logic             scl, scl_next;
  logic             sda, sda_next;
  logic             ack, ack_next;
  logic [7:0]       last_read, last_read_next;
  logic             done, rejected;

  logic [DIV_W-1:0] phase_len;
  logic [DIV_W:0]   div_inc;
  logic [3:0]       bit_inc;
  logic             busy;

  assign busy      = (cmd != CMD_IDLE);
  assign phase_len = (ticks_per_phase == '0) ? DIV_W'(1) : ticks_per_phase;
  assign div_inc   = {1'b0, div} + (DIV_W+1)'(1);
  assign bit_inc   = bit_idx + 4'd1;

  // Next state.
  always_comb begin
    cmd_next       = cmd;
    step_next      = step;
    bit_idx_next   = bit_idx;
    shift_next     = shift;
    div_next       = div;
    scl_next       = scl;
    sda_next       = sda;
    ack_next       = ack;
    last_read_next = last_read;
    done           = 1'b0;
    rejected       = 1'b0;
    if (fire) begin
      if (opcode == OP_TICK) begin
        if (busy) begin
          if (div_inc >= {1'b0, phase_len}) begin
            div_next = '0;
            case (cmd)
              CMD_START: begin
                if (step == 2'd0) begin
                  sda_next  = 1'b0;
                  step_next = 2'd1;
                end else begin
                  scl_next = 1'b0;
                  done     = 1'b1;
                end
              end
              CMD_STOP: begin
                sda_next = 1'b1;
                done     = 1'b1;
              end
              CMD_WRITE: begin
                if (bit_idx < 4'd8) begin
                  if (step == 2'd0) begin
                    scl_next  = 1'b1;
                    step_next = 2'd1;
                  end else if (step == 2'd1) begin
                    scl_next = 1'b0;
                    if (bit_idx == 4'd7) sda_next = 1'b1;
                    step_next = 2'd2;
                  end else begin
                    bit_idx_next = bit_inc;
                    shift_next   = {shift[6:0], 1'b0};
                    sda_next     = (bit_inc < 4'd8) ? shift[6] : 1'b1;
                    step_next    = 2'd0;
                  end
                end else begin
                  if (step == 2'd0) begin
                    scl_next  = 1'b1;
                    step_next = 2'd1;
                  end else if (step == 2'd1) begin
                    ack_next  = ~sda_in;
                    scl_next  = 1'b0;
                    step_next = 2'd2;
                  end else begin
                    done = 1'b1;
                  end
                end
              end
              CMD_READ_ACK, CMD_READ_NACK: begin
                if (bit_idx < 4'd8) begin
                  if (step == 2'd0) begin
                    shift_next = {shift[6:0], sda_in};
                    scl_next   = 1'b0;
                    step_next  = 2'd1;
                  end else begin
                    bit_idx_next = bit_inc;
                    step_next    = 2'd0;
                    if (bit_inc < 4'd8) begin
                      scl_next = 1'b1;
                    end else begin
                      last_read_next = shift;
                      sda_next       = (cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
                    end
                  end
                end else begin
                  if (step == 2'd0) begin
                    scl_next  = 1'b1;
                    step_next = 2'd1;
                  end else if (step == 2'd1) begin
                    scl_next  = 1'b0;
                    step_next = 2'd2;
                  end else begin
                    if (cmd == CMD_READ_ACK) sda_next = 1'b1;
                    done = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
            if (done) begin
              cmd_next     = CMD_IDLE;
              step_next    = 2'd0;
              bit_idx_next = 4'd0;
            end
          end else begin
            div_next = div_inc[DIV_W-1:0];
          end
        end
      end else if (opcode <= OP_READ_NACK) begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          cmd_next     = cmd_t'(opcode);
          step_next    = 2'd0;
          bit_idx_next = 4'd0;
          div_next     = '0;
          case (opcode)
            OP_START: begin
              scl_next = 1'b1;
              sda_next = 1'b1;
            end
            OP_STOP: begin
              sda_next = 1'b0;
              scl_next = 1'b1;
            end
            OP_WRITE: begin
              shift_next = data_byte;
              sda_next   = data_byte[7];
            end
            default: begin
              shift_next = 8'd0;
              sda_next   = 1'b1;
              scl_next   = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Result of the item, taken from the updated state.
  always_comb begin
    res.scl_release  = scl_next;
    res.sda_release  = sda_next;
    res.busy_res     = (cmd_next != CMD_IDLE);
    res.done_res     = done;
    res.ack_seen     = ack_next;
    res.read_data    = last_read_next;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd       <= CMD_IDLE;
      step      <= 2'd0;
      bit_idx   <= 4'd0;
      shift     <= 8'd0;
      div       <= '0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      ack       <= 1'b0;
      last_read <= 8'd0;
    end else begin
      cmd       <= cmd_next;
      step      <= step_next;
      bit_idx   <= bit_idx_next;
      shift     <= shift_next;
      div       <= div_next;
      scl       <= scl_next;
      sda       <= sda_next;
      ack       <= ack_next;
      last_read <= last_read_next;
    end
  end

endmodule

[design/i2cms_out_reg.sv]
// Result register that drives the output channel.
module i2cms_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cms_pkg::res_t in_res,
  i2cms_res_if.source     res
);
  import i2cms_pkg::*;

  logic valid;
  res_t data;

  // A held result is replaced in the same cycle it is taken.
  assign in_ready = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_res;
    end
  end

  assign res.valid        = valid;
  assign res.scl_release  = data.scl_release;
  assign res.sda_release  = data.sda_release;
  assign res.busy_res     = data.busy_res;
  assign res.done_res     = data.done_res;
  assign res.ack_seen     = data.ack_seen;
  assign res.read_data    = data.read_data;
  assign res.cmd_rejected = data.cmd_rejected;

endmodule
